FILE: design/qpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int unsigned MAX_SLOTS_DEF    = 1024;
  localparam int unsigned SIZE_W           = 10;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned VAL_W            = 32;
  localparam int unsigned DIV_CNT_W        = 5;
  localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = 10'd11;
  localparam logic [SIZE_W-1:0] MIN_TABLE_SIZE   = 10'd3;

  typedef enum logic [1:0] {
    RES_STORED  = 2'd0,
    RES_FOUND   = 2'd1,
    RES_MISSING = 2'd2,
    RES_FULL    = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic occ;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic div_step;
    logic fix;
    logic rd;
    logic adv;
    logic wr;
    logic set_res;
    res_e res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic mode_get;
    logic full;
    logic empty;
    logic match;
    logic last_probe;
    logic out_free;
  } sts_t;

endpackage

FILE: design/qpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_ctrl
// Sequencer for clearing, home slot division and the probe walk.
// ----------------------------------------------------------------------------
module qpht_ctrl import qpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_last) state_d = ST_FIX;
      ST_FIX: begin
        if (!sts_i.mode_get && sts_i.full) state_d = ST_DONE;
        else state_d = ST_RD;
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        if (sts_i.empty || (sts_i.mode_get && sts_i.match) || sts_i.last_probe) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_DONE: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res = RES_STORED;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        if (!sts_i.mode_get && sts_i.full) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res = RES_FULL;
        end
      end
      ST_RD: cmd_o.rd = 1'b1;
      ST_CHK: begin
        if (sts_i.mode_get) begin
          if (sts_i.empty) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res = RES_MISSING;
          end else if (sts_i.match) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res = RES_FOUND;
          end else if (sts_i.last_probe) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res = RES_MISSING;
          end else begin
            cmd_o.adv = 1'b1;
          end
        end else begin
          if (sts_i.empty) begin
            cmd_o.wr = 1'b1;
            cmd_o.set_res = 1'b1;
            cmd_o.res = RES_STORED;
          end else if (sts_i.last_probe) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res = RES_FULL;
          end else begin
            cmd_o.adv = 1'b1;
          end
        end
      end
      ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: design/qpht_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_dp
// Datapath: size register, serial divider, probe stepping and slot memory.
// ----------------------------------------------------------------------------
module qpht_dp import qpht_pkg::*; #(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_mode_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [VAL_W-1:0]  in_val_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_status_o,
  output logic [VAL_W-1:0]  out_value_o,
  output logic [SIZE_W-1:0] out_slot_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  localparam int unsigned AW = $clog2(MaxSlots);

  entry_t mem [MaxSlots];
  entry_t rd_q;

  logic [SIZE_W-1:0] table_size_q, n_w;
  logic [SIZE_W-1:0] entry_count_q;
  logic [AW-1:0] clr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic mode_q, neg_q;
  logic [KEY_W-1:0] key_q, mag_q;
  logic [VAL_W-1:0] val_q;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W:0] rem_t;
  logic [SIZE_W-1:0] pos_q, d_q, i_q, pos_d, d_d;
  logic [SIZE_W:0] pos_sum, d_sum;
  logic [AW-1:0] addr_w;
  logic out_valid_q;
  res_e res_q, out_res_q;
  logic [VAL_W-1:0] res_val_q, out_val_q;
  logic [SIZE_W-1:0] res_slot_q, out_slot_q;

  always_comb begin
    if (table_size_q < MIN_TABLE_SIZE) begin
      n_w = MIN_TABLE_SIZE;
    end else if (32'(table_size_q) > MaxSlots) begin
      n_w = SIZE_W'(MaxSlots);
    end else begin
      n_w = table_size_q;
    end
  end

  always_comb begin
    rem_t = {rem_q, mag_q[KEY_W-1]};
    if (rem_t >= {1'b0, n_w}) rem_d = SIZE_W'(rem_t - {1'b0, n_w});
    else rem_d = rem_t[SIZE_W-1:0];
    pos_sum = {1'b0, pos_q} + {1'b0, d_q};
    if (pos_sum >= {1'b0, n_w}) pos_d = SIZE_W'(pos_sum - {1'b0, n_w});
    else pos_d = pos_sum[SIZE_W-1:0];
    d_sum = {1'b0, d_q} + (SIZE_W+1)'(2);
    if (d_sum >= {1'b0, n_w}) d_d = SIZE_W'(d_sum - {1'b0, n_w});
    else d_d = d_sum[SIZE_W-1:0];
  end

  assign addr_w = cmd_i.clr_we ? clr_q : AW'(32'(pos_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q  <= RESET_TABLE_SIZE;
      entry_count_q <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) table_size_q <= cfg_data_i;
      if (cmd_i.clr_we) clr_q <= clr_q + AW'(1);
      if (cmd_i.wr) entry_count_q <= entry_count_q + SIZE_W'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      key_q  <= in_key_i;
      val_q  <= in_val_i;
      neg_q  <= in_key_i[KEY_W-1];
      mag_q  <= in_key_i[KEY_W-1] ? (~in_key_i + KEY_W'(1)) : in_key_i;
      rem_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      mag_q <= {mag_q[KEY_W-2:0], 1'b0};
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.fix) begin
      pos_q <= (neg_q && (rem_q != '0)) ? (n_w - rem_q) : rem_q;
      d_q   <= SIZE_W'(1);
      i_q   <= '0;
    end
    if (cmd_i.adv) begin
      pos_q <= pos_d;
      d_q   <= d_d;
      i_q   <= i_q + SIZE_W'(1);
    end
    if (cmd_i.set_res) begin
      res_q      <= cmd_i.res;
      res_val_q  <= (cmd_i.res == RES_FOUND) ? rd_q.val : '0;
      res_slot_q <= ((cmd_i.res == RES_FOUND) || (cmd_i.res == RES_STORED)) ? pos_q : '0;
    end
    if (cmd_i.out_load) begin
      out_res_q  <= res_q;
      out_val_q  <= res_val_q;
      out_slot_q <= res_slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      mem[addr_w] <= '0;
    end else if (cmd_i.wr) begin
      mem[addr_w] <= '{occ: 1'b1, key: key_q, val: val_q};
    end
    if (cmd_i.rd) rd_q <= mem[addr_w];
  end

  always_comb begin
    sts_o.clr_last   = (clr_q == AW'(MaxSlots - 1));
    sts_o.div_last   = (cnt_q == DIV_CNT_W'(KEY_W - 1));
    sts_o.mode_get   = mode_q;
    sts_o.full       = ((SIZE_W+1)'(entry_count_q) + (SIZE_W+1)'(1)) >=
                       (SIZE_W+1)'(n_w >> 1);
    sts_o.empty      = !rd_q.occ;
    sts_o.match      = (rd_q.key == key_q);
    sts_o.last_probe = (i_q == (n_w - SIZE_W'(1)));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_res_q;
  assign out_value_o  = out_val_q;
  assign out_slot_o   = out_slot_q;

`ifndef SYNTHESIS
  a_wr_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> !rd_q.occ) else $error("write into an occupied slot");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (pos_q < n_w)) else $error("probe position beyond table size");
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix |-> (rem_q < n_w)) else $error("remainder not below table size");
  a_rd_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fix && !cmd_i.set_res) |=> cmd_i.rd) else $error("probe did not follow home slot");
`endif

endmodule

FILE: design/quadratic_probe_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top
// Open-addressing hash table with quadratic probing, put and get by key.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word passes through an accept state, the
// bit-serial home slot divider, a fix-up state, a read state and a check
// state per probe on the single slot memory port, and a state that hands
// over the result. After reset the table is cleared by a pass over all
// MAX_SLOTS slots during which no word is accepted.
module quadratic_probe_hash_table_top import qpht_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i,    // table_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // value_out[31:0], slot[41:32], zero
  output logic [1:0]  m_axis_tuser   // status
);

  cmd_t cmd;
  sts_t sts;
  logic [VAL_W-1:0] value_out;
  logic [SIZE_W-1:0] slot;

  assign cfg_ready_o = 1'b1;

  qpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qpht_dp #(.MaxSlots(MAX_SLOTS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_mode_i    (s_axis_tuser),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_val_i     (s_axis_tdata[63:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (value_out),
    .out_slot_o   (slot),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  assign m_axis_tdata = {6'd0, slot, value_out};

endmodule
